// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TAU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("texture address unit check failed");

// Next-cycle implication.
`define TAU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("texture address unit check failed");

`endif

// ----- hw/rtl/tau_pkg.sv -----
package tau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SIZE_LOG2 = 12;

    localparam int COORD_W   = 32;
    localparam int INT_W     = COORD_W - FRAC_BITS + 1;   // integer part plus carry room
    localparam int T_W       = INT_W - 1;                 // folded (non-negative) coordinate
    localparam int SIZE_W    = SIZE_LOG2 + 1;
    localparam int CO_W      = SIZE_LOG2;                 // texel coordinate
    localparam int PROD_W    = COORD_W + SIZE_W + 1;
    localparam int IDX_W     = 24;
    localparam int WGT_W     = 16;
    localparam int CFG_W     = 13;
    localparam int REGIDX_W  = 3;
    localparam int NUM_CELLS = T_W;                       // one quotient bit per cell
    localparam int NUM_LANES = 4;

    localparam longint HALF    = longint'(1) << (FRAC_BITS - 1);
    localparam longint SAT_MAX = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint SAT_MIN = -(longint'(1) << (COORD_W - 1));

    // register indexes
    localparam logic [REGIDX_W-1:0] REG_COORD_MAPPING  = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_FILTER_MODE    = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_ADDRESS_MODE_U = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_ADDRESS_MODE_V = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_IMAGE_WIDTH    = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd5;

    // address modes (code three behaves as clamp)
    localparam logic [1:0] MODE_WRAP   = 2'd0;
    localparam logic [1:0] MODE_CLAMP  = 2'd1;
    localparam logic [1:0] MODE_MIRROR = 2'd2;

    // lane numbering inside the chain
    localparam int LANE_U_LO = 0;
    localparam int LANE_U_HI = 1;
    localparam int LANE_V_LO = 2;
    localparam int LANE_V_HI = 3;

    typedef struct packed {
        logic [T_W-1:0]  dvd;     // dividend bits still to shift in
        logic [CO_W-1:0] rem;     // partial remainder
        logic            q;       // latest quotient bit (parity at the end)
        logic            neg;     // coordinate was negative
        logic [CO_W-1:0] clamp;   // clamp-mode result
    } lane_t;

    typedef struct packed {
        logic             bilinear;
        logic [WGT_W-1:0] wu;
        logic [WGT_W-1:0] wv;
    } side_t;

    typedef struct packed {
        lane_t [NUM_LANES-1:0] lane;
        side_t                 side;
    } stage_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] s);
        logic [SIZE_W-1:0] n;
        if (s == '0)
            n = SIZE_W'(1);
        else if (int'(s) > (1 << SIZE_LOG2))
            n = SIZE_W'(1 << SIZE_LOG2);
        else
            n = SIZE_W'(s);
        return n;
    endfunction

endpackage

// ----- hw/rtl/tau_scale.sv -----
module tau_scale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [tau_pkg::COORD_W-1:0]   coord_u,
    input  logic signed [tau_pkg::COORD_W-1:0]   coord_v,
    input  logic                                 mapping,
    input  logic                                 filter,
    input  logic [tau_pkg::SIZE_W-1:0]           size_w,
    input  logic [tau_pkg::SIZE_W-1:0]           size_h,
    input  logic                                 ready_down,
    output logic                                 ready_up,
    output logic                                 out_valid,
    output tau_pkg::stage_t                      out_stage
);

    typedef struct packed {
        tau_pkg::lane_t                 lo;
        tau_pkg::lane_t                 hi;
        logic [tau_pkg::WGT_W-1:0]      wgt;
    } axis_t;

    logic                                v1_reg, v1_next;
    logic                                v2_reg, v2_next;
    logic signed [tau_pkg::PROD_W-1:0]   prod_u_reg, prod_v_reg;
    logic signed [tau_pkg::COORD_W-1:0]  cu_reg, cv_reg;
    tau_pkg::stage_t                     st_reg, st_next;
    logic                                load1, load2;
    axis_t                               ax_u, ax_v;

    function automatic tau_pkg::lane_t lane_prep(
        input logic signed [tau_pkg::INT_W-1:0] i,
        input logic [tau_pkg::SIZE_W-1:0]       n
    );
        tau_pkg::lane_t l;
        l.neg = i[tau_pkg::INT_W-1];
        l.dvd = l.neg ? ~i[tau_pkg::T_W-1:0] : i[tau_pkg::T_W-1:0];
        l.rem = '0;
        l.q   = 1'b0;
        if (l.neg)
            l.clamp = '0;
        else if (int'(i[tau_pkg::T_W-1:0]) >= int'(n))
            l.clamp = tau_pkg::CO_W'(n - 1'b1);
        else
            l.clamp = tau_pkg::CO_W'(i[tau_pkg::T_W-1:0]);
        return l;
    endfunction

    function automatic axis_t axis_prep(
        input logic signed [tau_pkg::PROD_W-1:0]  prod,
        input logic signed [tau_pkg::COORD_W-1:0] coord,
        input logic                               map_n,
        input logic                               bil,
        input logic [tau_pkg::SIZE_W-1:0]         n
    );
        logic signed [tau_pkg::PROD_W-1:0]  r;
        logic signed [tau_pkg::COORD_W-1:0] c;
        logic signed [tau_pkg::COORD_W:0]   cp;
        logic signed [tau_pkg::INT_W-1:0]   ilo, ihi, ipt;
        logic [tau_pkg::FRAC_BITS-1:0]      frac;
        axis_t                              a;
        r = prod - tau_pkg::PROD_W'(tau_pkg::HALF);
        if (r > tau_pkg::PROD_W'(tau_pkg::SAT_MAX))
            r = tau_pkg::PROD_W'(tau_pkg::SAT_MAX);
        else if (r < tau_pkg::PROD_W'(tau_pkg::SAT_MIN))
            r = tau_pkg::PROD_W'(tau_pkg::SAT_MIN);
        c    = map_n ? tau_pkg::COORD_W'(r) : coord;
        cp   = {c[tau_pkg::COORD_W-1], c} + (tau_pkg::COORD_W + 1)'(tau_pkg::HALF);
        ipt  = tau_pkg::INT_W'(cp >>> tau_pkg::FRAC_BITS);
        ilo  = tau_pkg::INT_W'(c >>> tau_pkg::FRAC_BITS);
        frac = c[tau_pkg::FRAC_BITS-1:0];
        ihi  = ilo + tau_pkg::INT_W'(frac != '0);
        a.lo  = lane_prep(bil ? ilo : ipt, n);
        a.hi  = lane_prep(ihi, n);
        a.wgt = tau_pkg::WGT_W'({frac, tau_pkg::WGT_W'(0)} >> tau_pkg::FRAC_BITS);
        return a;
    endfunction

    assign load2    = !v2_reg || ready_down;
    assign load1    = !v1_reg || load2;
    assign ready_up = load1;
    assign v1_next  = load1 ? in_valid : v1_reg;
    assign v2_next  = load2 ? v1_reg : v2_reg;

    always_comb
    begin
        ax_u = axis_prep(prod_u_reg, cu_reg, mapping, filter, size_w);
        ax_v = axis_prep(prod_v_reg, cv_reg, mapping, filter, size_h);
        st_next = '0;
        st_next.lane[tau_pkg::LANE_U_LO] = ax_u.lo;
        st_next.lane[tau_pkg::LANE_U_HI] = ax_u.hi;
        st_next.lane[tau_pkg::LANE_V_LO] = ax_v.lo;
        st_next.lane[tau_pkg::LANE_V_HI] = ax_v.hi;
        st_next.side.bilinear = filter;
        st_next.side.wu       = ax_u.wgt;
        st_next.side.wv       = ax_v.wgt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            prod_u_reg <= coord_u * $signed({1'b0, size_w});
            prod_v_reg <= coord_v * $signed({1'b0, size_h});
            cu_reg     <= coord_u;
            cv_reg     <= coord_v;
        end
        if (load2)
            st_reg <= st_next;
    end

    assign out_valid = v2_reg;
    assign out_stage = st_reg;

endmodule

// ----- hw/rtl/tau_cell.sv -----
// One restoring-division step on all four lanes.
module tau_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  tau_pkg::stage_t              in_stage,
    input  logic [tau_pkg::SIZE_W-1:0]   size_w,
    input  logic [tau_pkg::SIZE_W-1:0]   size_h,
    input  logic                         ready_down,
    output logic                         ready_up,
    output logic                         out_valid,
    output tau_pkg::stage_t              out_stage
);

    logic                 valid_reg, valid_next;
    tau_pkg::stage_t      st_reg, st_next;
    logic                 load;

    assign load       = !valid_reg || ready_down;
    assign ready_up   = load;
    assign valid_next = load ? in_valid : valid_reg;

    always_comb
    begin
        logic [tau_pkg::SIZE_W-1:0] n;
        logic [tau_pkg::SIZE_W-1:0] r2;
        st_next = in_stage;
        for (int k = 0; k < tau_pkg::NUM_LANES; k++)
        begin
            n  = (k < tau_pkg::LANE_V_LO) ? size_w : size_h;
            r2 = {in_stage.lane[k].rem, in_stage.lane[k].dvd[tau_pkg::T_W-1]};
            if (r2 >= n)
            begin
                st_next.lane[k].rem = tau_pkg::CO_W'(r2 - n);
                st_next.lane[k].q   = 1'b1;
            end
            else
            begin
                st_next.lane[k].rem = r2[tau_pkg::CO_W-1:0];
                st_next.lane[k].q   = 1'b0;
            end
            st_next.lane[k].dvd = in_stage.lane[k].dvd << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            st_reg <= st_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = st_reg;

endmodule

// ----- hw/rtl/tau_index.sv -----
module tau_index (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  tau_pkg::stage_t              in_stage,
    input  logic [1:0]                   mode_u,
    input  logic [1:0]                   mode_v,
    input  logic [tau_pkg::SIZE_W-1:0]   size_w,
    input  logic [tau_pkg::SIZE_W-1:0]   size_h,
    input  logic                         ready_down,
    output logic                         ready_up,
    output logic                         out_valid,
    output logic [tau_pkg::IDX_W-1:0]    index_top_left,
    output logic [tau_pkg::IDX_W-1:0]    index_top_right,
    output logic [tau_pkg::IDX_W-1:0]    index_bottom_left,
    output logic [tau_pkg::IDX_W-1:0]    index_bottom_right,
    output logic [tau_pkg::WGT_W-1:0]    weight_u,
    output logic [tau_pkg::WGT_W-1:0]    weight_v,
    output logic                         is_bilinear
);

    localparam int SUM_W = tau_pkg::CO_W + tau_pkg::SIZE_W + 1;

    logic                          valid_reg, valid_next, load;
    logic [tau_pkg::IDX_W-1:0]     tl_reg, tr_reg, bl_reg, br_reg;
    logic [tau_pkg::IDX_W-1:0]     tl_next, tr_next, bl_next, br_next;
    logic [tau_pkg::WGT_W-1:0]     wu_reg, wv_reg, wu_next, wv_next;
    logic                          bil_reg;
    logic [tau_pkg::CO_W-1:0]      col0, col1, row0, row1;

    function automatic logic [tau_pkg::CO_W-1:0] fold(
        input logic [1:0]                 mode,
        input logic [tau_pkg::SIZE_W-1:0] n,
        input tau_pkg::lane_t             l
    );
        logic [tau_pkg::CO_W-1:0] refl;
        logic [tau_pkg::CO_W-1:0] c;
        refl = tau_pkg::CO_W'(n - 1'b1 - tau_pkg::SIZE_W'(l.rem));
        unique case (mode)
            tau_pkg::MODE_WRAP:   c = l.neg ? refl : l.rem;  // negative: n-1 - (~i mod n)
            tau_pkg::MODE_MIRROR: c = l.q ? refl : l.rem;    // odd period runs backward
            default:              c = l.clamp;
        endcase
        return c;
    endfunction

    function automatic logic [tau_pkg::IDX_W-1:0] lin(
        input logic [tau_pkg::CO_W-1:0]   row,
        input logic [tau_pkg::CO_W-1:0]   col,
        input logic [tau_pkg::SIZE_W-1:0] w
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(row) * SUM_W'(w) + SUM_W'(col);
        return tau_pkg::IDX_W'(s);
    endfunction

    assign load       = !valid_reg || ready_down;
    assign ready_up   = load;
    assign valid_next = load ? in_valid : valid_reg;

    always_comb
    begin
        col0 = fold(mode_u, size_w, in_stage.lane[tau_pkg::LANE_U_LO]);
        col1 = fold(mode_u, size_w, in_stage.lane[tau_pkg::LANE_U_HI]);
        row0 = fold(mode_v, size_h, in_stage.lane[tau_pkg::LANE_V_LO]);
        row1 = fold(mode_v, size_h, in_stage.lane[tau_pkg::LANE_V_HI]);
        tl_next = lin(row0, col0, size_w);
        if (in_stage.side.bilinear)
        begin
            tr_next = lin(row0, col1, size_w);
            bl_next = lin(row1, col0, size_w);
            br_next = lin(row1, col1, size_w);
            wu_next = in_stage.side.wu;
            wv_next = in_stage.side.wv;
        end
        else
        begin
            tr_next = '0;
            bl_next = '0;
            br_next = '0;
            wu_next = '0;
            wv_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tl_reg  <= tl_next;
            tr_reg  <= tr_next;
            bl_reg  <= bl_next;
            br_reg  <= br_next;
            wu_reg  <= wu_next;
            wv_reg  <= wv_next;
            bil_reg <= in_stage.side.bilinear;
        end
    end

    assign out_valid          = valid_reg;
    assign index_top_left     = tl_reg;
    assign index_top_right    = tr_reg;
    assign index_bottom_left  = bl_reg;
    assign index_bottom_right = br_reg;
    assign weight_u           = wu_reg;
    assign weight_v           = wv_reg;
    assign is_bilinear        = bil_reg;

endmodule

// ----- hw/rtl/texture_address_unit_core.sv -----
// Texture address unit: turns a signed Q16.16 (u, v) pair into row-major texel
// indices and bilinear weights, with wrap, clamp or mirror addressing per axis.
// One transaction is accepted per clock unless stalled and leaves in order
// through a scale multiply, a floor/saturate stage, 16 division cells that each
// resolve one quotient bit of the wrap/mirror modulo on all four coordinates, and
// an index multiply stage that is the output register. Stall propagates backward
// per stage, so empty stages keep filling while the output waits. Configuration
// must only be written with no transaction in flight; it is not enforced.
`include "assert_macros.svh"

module texture_address_unit_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 write_enable,
    input  logic [tau_pkg::REGIDX_W-1:0]         reg_index,
    input  logic [tau_pkg::CFG_W-1:0]            write_data,
    // coordinate channel
    input  logic                                 coord_valid,
    output logic                                 coord_stall,
    input  logic signed [tau_pkg::COORD_W-1:0]   coord_u,
    input  logic signed [tau_pkg::COORD_W-1:0]   coord_v,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [tau_pkg::IDX_W-1:0]            index_top_left,
    output logic [tau_pkg::IDX_W-1:0]            index_top_right,
    output logic [tau_pkg::IDX_W-1:0]            index_bottom_left,
    output logic [tau_pkg::IDX_W-1:0]            index_bottom_right,
    output logic [tau_pkg::WGT_W-1:0]            weight_u,
    output logic [tau_pkg::WGT_W-1:0]            weight_v,
    output logic                                 is_bilinear
);

    // configuration registers
    logic                          mapping_reg;
    logic                          filter_reg;
    logic [1:0]                    mode_u_reg, mode_v_reg;
    logic [tau_pkg::CFG_W-1:0]     width_reg, height_reg;
    logic [tau_pkg::SIZE_W-1:0]    size_w, size_h;

    // chain wiring: element k feeds cell k
    logic                          chain_valid [tau_pkg::NUM_CELLS+1];
    tau_pkg::stage_t               chain_stage [tau_pkg::NUM_CELLS+1];
    logic                          chain_ready [tau_pkg::NUM_CELLS+1];
    logic                          front_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapping_reg <= 1'b0;
            filter_reg  <= 1'b0;
            mode_u_reg  <= tau_pkg::MODE_WRAP;
            mode_v_reg  <= tau_pkg::MODE_WRAP;
            width_reg   <= tau_pkg::CFG_W'(1);
            height_reg  <= tau_pkg::CFG_W'(1);
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                tau_pkg::REG_COORD_MAPPING:  mapping_reg <= write_data[0];
                tau_pkg::REG_FILTER_MODE:    filter_reg  <= write_data[0];
                tau_pkg::REG_ADDRESS_MODE_U: mode_u_reg  <= write_data[1:0];
                tau_pkg::REG_ADDRESS_MODE_V: mode_v_reg  <= write_data[1:0];
                tau_pkg::REG_IMAGE_WIDTH:    width_reg   <= write_data;
                tau_pkg::REG_IMAGE_HEIGHT:   height_reg  <= write_data;
                default:                     ;  // unused index, dropped
            endcase
        end
    end

    // zero reads as one, anything above the maximum image size saturates
    assign size_w = tau_pkg::eff_size(width_reg);
    assign size_h = tau_pkg::eff_size(height_reg);

    // scale, round/floor, and fold negatives to one's complement for the modulo
    tau_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (coord_valid),
        .coord_u    (coord_u),
        .coord_v    (coord_v),
        .mapping    (mapping_reg),
        .filter     (filter_reg),
        .size_w     (size_w),
        .size_h     (size_h),
        .ready_down (chain_ready[0]),
        .ready_up   (front_ready),
        .out_valid  (chain_valid[0]),
        .out_stage  (chain_stage[0])
    );

    assign coord_stall = !front_ready;

    // one quotient bit per cell, MSB first; last cell holds remainder and parity
    for (genvar g = 0; g < tau_pkg::NUM_CELLS; g++)
    begin : g_cell
        tau_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (chain_valid[g]),
            .in_stage   (chain_stage[g]),
            .size_w     (size_w),
            .size_h     (size_h),
            .ready_down (chain_ready[g+1]),
            .ready_up   (chain_ready[g]),
            .out_valid  (chain_valid[g+1]),
            .out_stage  (chain_stage[g+1])
        );
    end

    // address mode select, row * width + column, output register
    tau_index u_index (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (chain_valid[tau_pkg::NUM_CELLS]),
        .in_stage           (chain_stage[tau_pkg::NUM_CELLS]),
        .mode_u             (mode_u_reg),
        .mode_v             (mode_v_reg),
        .size_w             (size_w),
        .size_h             (size_h),
        .ready_down         (!result_stall),
        .ready_up           (chain_ready[tau_pkg::NUM_CELLS]),
        .out_valid          (result_valid),
        .index_top_left     (index_top_left),
        .index_top_right    (index_top_right),
        .index_bottom_left  (index_bottom_left),
        .index_bottom_right (index_bottom_right),
        .weight_u           (weight_u),
        .weight_v           (weight_v),
        .is_bilinear        (is_bilinear)
    );

    // point-sampled results carry only the top-left texel
    `TAU_ASSERT_IMP(a_point_zero, result_valid && !is_bilinear, index_top_right == '0 && index_bottom_left == '0 && index_bottom_right == '0 && weight_u == '0 && weight_v == '0)
    // filter mode is static while transactions are in flight
    `TAU_ASSERT_IMP(a_filter_match, result_valid, is_bilinear == filter_reg)
    // an empty output register means every stage can advance
    `TAU_ASSERT_IMP(a_no_stall_empty, !result_valid, !coord_stall)
    // filter mode write lands
    `TAU_ASSERT_NXT(a_cfg_filter, write_enable && reg_index == tau_pkg::REG_FILTER_MODE, filter_reg == $past(write_data[0]))

endmodule
